/* rtl/kpi_pkg.sv */
// Shared types, constants and key field helpers for the keyframe position interpolator.
package kpi_pkg;

  localparam int KEY_W       = 48;
  localparam int COORD_W     = 16;
  localparam int FRAME_W     = 16;
  localparam int COUNT_W     = 3;
  localparam int CFG_IDX_W   = 3;
  localparam int WEIGHT_BITS = 8;
  localparam int DIV_CNT_W   = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_KEY_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_FIRST = 3'd1;

  // Last step of the weight division
  localparam logic [DIV_CNT_W-1:0] DIV_LAST = 3'(WEIGHT_BITS - 1);

  // Controller to datapath commands
  typedef struct packed {
    logic take_frame;
    logic prev_load;
    logic take_end;
    logic seg_load;
    logic take_last;
    logic div_step;
    logic mul;
    logic sum;
    logic out_load;
  } kpi_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic enough_keys;
    logic hit_end;
    logic hit_inside;
    logic last_key;
  } kpi_stat_t;

  function automatic logic [FRAME_W-1:0] key_frame(input logic [KEY_W-1:0] k);
    return k[47:32];
  endfunction

  function automatic logic [COORD_W-1:0] key_x(input logic [KEY_W-1:0] k);
    return k[31:16];
  endfunction

  function automatic logic [COORD_W-1:0] key_y(input logic [KEY_W-1:0] k);
    return k[15:0];
  endfunction

endpackage

/* rtl/kpi_if.sv */
// Stream interfaces for frame numbers in and positions out.
interface kpi_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] frame_number;

  modport source (output valid, output frame_number, input ready);
  modport sink   (input valid, input frame_number, output ready);
endinterface

interface kpi_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic               done_res;

  modport source (output valid, output pos_x, output pos_y, output done_res, input ready);
  modport sink   (input valid, input pos_x, input pos_y, input done_res, output ready);
endinterface

/* rtl/kpi_datapath.sv */
// Datapath: key table, segment compare, restoring divider, blend and output register.
module kpi_datapath #(
  parameter int MAX_KEYS = 6,
  parameter int KIDX_W   = 3
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_we,
  input  logic [kpi_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [kpi_pkg::KEY_W-1:0]             cfg_data,
  input  logic [kpi_pkg::FRAME_W-1:0]           in_frame,
  input  kpi_pkg::kpi_cmd_t                     cmd,
  input  logic [KIDX_W-1:0]                     key_sel,
  output kpi_pkg::kpi_stat_t                    stat,
  output logic signed [kpi_pkg::COORD_W-1:0]    pos_x,
  output logic signed [kpi_pkg::COORD_W-1:0]    pos_y,
  output logic                                  done_res
);

  localparam int FW = kpi_pkg::FRAME_W;
  localparam int CW = kpi_pkg::COORD_W;
  localparam int PW = CW + 1 + kpi_pkg::WEIGHT_BITS + 1;

  logic [kpi_pkg::COUNT_W-1:0] key_count;
  logic [kpi_pkg::KEY_W-1:0]   keys [MAX_KEYS];
  logic [FW-1:0]               frame;
  logic [kpi_pkg::KEY_W-1:0]   prev_key;
  logic [CW-1:0]               cur_x;
  logic [CW-1:0]               cur_y;
  logic                        finished;
  logic [FW-1:0]               span;
  logic [FW-1:0]               rem;
  logic [kpi_pkg::WEIGHT_BITS-1:0] t;
  logic [CW-1:0]               ax;
  logic [CW-1:0]               ay;
  logic signed [CW:0]          dx;
  logic signed [CW:0]          dy;
  logic [CW-1:0]               px;
  logic [CW-1:0]               py;

  logic [kpi_pkg::COUNT_W-1:0] n_clamp;
  logic [kpi_pkg::KEY_W-1:0]   sel_key;
  logic [FW-1:0]               f0;
  logic [FW-1:0]               f1;
  logic [FW:0]                 rem_sh;
  logic                        rem_ge;
  logic [FW:0]                 rem_diff;
  logic signed [PW-1:0]        prod_x;
  logic signed [PW-1:0]        prod_y;

  // Clamp the key count and pick the segment under test
  assign n_clamp = (key_count > kpi_pkg::COUNT_W'(MAX_KEYS)) ?
                   kpi_pkg::COUNT_W'(MAX_KEYS) : key_count;
  assign sel_key = keys[key_sel];
  assign f0      = kpi_pkg::key_frame(prev_key);
  assign f1      = kpi_pkg::key_frame(sel_key);

  assign stat.enough_keys = n_clamp >= kpi_pkg::COUNT_W'(2);
  assign stat.hit_end     = frame == f1;
  assign stat.hit_inside  = (f0 <= frame) && (frame < f1);
  assign stat.last_key    = kpi_pkg::COUNT_W'(key_sel) == (n_clamp - kpi_pkg::COUNT_W'(1));

  // One quotient bit per step
  assign rem_sh   = {rem, 1'b0};
  assign rem_ge   = rem_sh >= {1'b0, span};
  assign rem_diff = rem_sh - {1'b0, span};

  assign prod_x = PW'(dx) * PW'($signed({1'b0, t}));
  assign prod_y = PW'(dy) * PW'($signed({1'b0, t}));

  // Write configuration registers; indexes past the table are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
    end else if (cfg_we && cfg_index == kpi_pkg::REG_KEY_COUNT) begin
      key_count <= cfg_data[kpi_pkg::COUNT_W-1:0];
    end
  end

  for (genvar k = 0; k < MAX_KEYS; k++) begin : g_key
    always_ff @(posedge clk) begin
      if (rst) begin
        keys[k] <= '0;
      end else if (cfg_we &&
                   cfg_index == kpi_pkg::REG_KEY_FIRST + kpi_pkg::CFG_IDX_W'(k)) begin
        keys[k] <= cfg_data;
      end
    end
  end

  // Position state and sticky finished flag
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x    <= '0;
      cur_y    <= '0;
      finished <= 1'b0;
    end else if (cmd.take_end) begin
      cur_x <= kpi_pkg::key_x(sel_key);
      cur_y <= kpi_pkg::key_y(sel_key);
    end else if (cmd.take_last) begin
      cur_x    <= kpi_pkg::key_x(sel_key);
      cur_y    <= kpi_pkg::key_y(sel_key);
      finished <= 1'b1;
    end else if (cmd.sum) begin
      cur_x <= ax + px;
      cur_y <= ay + py;
    end
  end

  // Working registers for the segment blend
  always_ff @(posedge clk) begin
    if (cmd.take_frame) begin
      frame <= in_frame;
    end
    if (cmd.prev_load) begin
      prev_key <= sel_key;
    end
    if (cmd.seg_load) begin
      span <= f1 - f0;
      rem  <= frame - f0;
      ax   <= kpi_pkg::key_x(prev_key);
      ay   <= kpi_pkg::key_y(prev_key);
      dx   <= $signed({sel_key[31], kpi_pkg::key_x(sel_key)}) -
              $signed({prev_key[31], kpi_pkg::key_x(prev_key)});
      dy   <= $signed({sel_key[15], kpi_pkg::key_y(sel_key)}) -
              $signed({prev_key[15], kpi_pkg::key_y(prev_key)});
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? rem_diff[FW-1:0] : rem_sh[FW-1:0];
      t   <= {t[kpi_pkg::WEIGHT_BITS-2:0], rem_ge};
    end
    // Arithmetic shift by the weight width, wrapped to the coordinate width
    if (cmd.mul) begin
      px <= prod_x[kpi_pkg::WEIGHT_BITS +: CW];
      py <= prod_y[kpi_pkg::WEIGHT_BITS +: CW];
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      pos_x    <= cur_x;
      pos_y    <= cur_y;
      done_res <= finished;
    end
  end

endmodule

/* rtl/kpi_ctrl.sv */
// Controller: segment scan, divide and blend sequencing, output beat handshake.
module kpi_ctrl #(
  parameter int KIDX_W = 3
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  kpi_pkg::kpi_stat_t stat,
  output kpi_pkg::kpi_cmd_t  cmd,
  output logic [KIDX_W-1:0]  key_sel
);

  localparam int DIV_W = kpi_pkg::DIV_CNT_W;

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_FETCH = 7'b0000010,
    S_SCAN  = 7'b0000100,
    S_DIV   = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_SUM   = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t                         state;
  state_t                         state_next;
  logic [DIV_W-1:0]               cnt;
  logic                           out_free;

  assign in_ready = state == S_IDLE;
  assign out_free = !out_valid || out_ready;

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_frame = 1'b1;
          state_next     = stat.enough_keys ? S_FETCH : S_OUT;
        end
      end
      S_FETCH: begin
        cmd.prev_load = 1'b1;
        state_next    = S_SCAN;
      end
      S_SCAN: begin
        if (stat.hit_end) begin
          cmd.take_end = 1'b1;
          state_next   = S_OUT;
        end else if (stat.hit_inside) begin
          cmd.seg_load = 1'b1;
          state_next   = S_DIV;
        end else if (stat.last_key) begin
          cmd.take_last = 1'b1;
          state_next    = S_OUT;
        end else begin
          cmd.prev_load = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (cnt == kpi_pkg::DIV_LAST) begin
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul    = 1'b1;
        state_next = S_SUM;
      end
      S_SUM: begin
        cmd.sum    = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State, key pointer and divide step counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      key_sel <= '0;
      cnt     <= '0;
    end else begin
      state <= state_next;
      if (cmd.take_frame) begin
        key_sel <= '0;
      end else if (cmd.prev_load) begin
        key_sel <= key_sel + 1'b1;
      end
      if (cmd.seg_load) begin
        cnt <= '0;
      end else if (cmd.div_step) begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  // Output beat valid: set on load, drop when taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  a_out_from_load: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == S_OUT))
    else $error("output beat raised without a load");

  a_mul_after_div: assert property (@(posedge clk) disable iff (rst)
    state == S_MUL |-> $past(state == S_DIV) && $past(cnt == kpi_pkg::DIV_LAST))
    else $error("blend started before the full weight was divided");

  a_out_stall_holds: assert property (@(posedge clk) disable iff (rst)
    state == S_OUT && out_valid && !out_ready |=> state == S_OUT)
    else $error("result dropped while the output beat was stalled");

  a_scan_from_fetch: assert property (@(posedge clk) disable iff (rst)
    $rose(state == S_SCAN) |-> $past(state == S_FETCH))
    else $error("segment scan entered without loading the first key");

endmodule

/* rtl/keyframe_position_interpolator_top.sv */
// Sequence: with fewer than two keys an accepted frame goes straight to the output state;
// otherwise the first key is loaded, segments are scanned one by one (up to MAX_KEYS-1),
// and an inner frame adds 8 restoring divider steps, a multiply and an add.
// Throughput: one item at a time; a new beat is taken while the previous result waits.
// Reset (rst, synchronous): clears key count, key table, position and finished flag.
module keyframe_position_interpolator_top #(
  parameter int MAX_KEYS = 6
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [kpi_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [kpi_pkg::KEY_W-1:0]     cfg_data,
  kpi_in_if.sink                        in_ch,
  kpi_out_if.source                     out_ch
);

  localparam int KIDX_W = $clog2(MAX_KEYS);

  kpi_pkg::kpi_cmd_t  cmd;
  kpi_pkg::kpi_stat_t stat;
  logic [KIDX_W-1:0]  key_sel;

  kpi_ctrl #(
    .KIDX_W(KIDX_W)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .out_valid(out_ch.valid),
    .out_ready(out_ch.ready),
    .stat     (stat),
    .cmd      (cmd),
    .key_sel  (key_sel)
  );

  kpi_datapath #(
    .MAX_KEYS(MAX_KEYS),
    .KIDX_W  (KIDX_W)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_frame (in_ch.frame_number),
    .cmd      (cmd),
    .key_sel  (key_sel),
    .stat     (stat),
    .pos_x    (out_ch.pos_x),
    .pos_y    (out_ch.pos_y),
    .done_res (out_ch.done_res)
  );

endmodule
